/* rtl/scrov_pkg.sv */
// Shared types and constants of the screen overlap selector.
// Holds the request, response and table entry layouts and the walk control structs.
// No dependencies.
package scrov_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HEIGHT = 2'd2;

    localparam logic [3:0]  SCREEN_COUNT_RST   = 4'd0;
    localparam logic [15:0] DEFAULT_WIDTH_RST  = 16'd1024;
    localparam logic [15:0] DEFAULT_HEIGHT_RST = 16'd768;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RECT  = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;
    localparam logic [1:0] OP_TOTAL = 2'd3;

    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_DEFAULT = 2'd1;
    localparam logic [1:0] KIND_BOUND   = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         entry_index;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
    } scrov_req_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [2:0]         screen_index;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [15:0]        out_width;
        logic [15:0]        out_height;
    } scrov_rsp_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
    } scrov_entry_t;

    typedef struct packed {
        logic start;
        logic ent_valid;
        logic ent_first;
    } scrov_walk_ctl_t;

    typedef struct packed {
        logic busy;
        logic found;
    } scrov_walk_sts_t;

endpackage

/* rtl/scrov_walk.sv */
// Entry evaluation pipeline of the screen overlap selector.
// Takes one table entry a cycle and keeps the best match and the bounding box.
// Depends on scrov_pkg.
module scrov_walk #(
    parameter int IDX_W = 3
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  scrov_pkg::scrov_walk_ctl_t ctl,
    input  scrov_pkg::scrov_req_t   query,
    input  logic [IDX_W-1:0]        ent_idx,
    input  scrov_pkg::scrov_entry_t ent,
    output scrov_pkg::scrov_walk_sts_t sts,
    output logic [IDX_W-1:0]        best_idx,
    output scrov_pkg::scrov_entry_t best_ent,
    output logic signed [15:0]      bound_x1,
    output logic signed [15:0]      bound_y1,
    output logic signed [17:0]      bound_x2,
    output logic signed [17:0]      bound_y2
);

    // stage 2: ends and lower overlap edges
    logic                    e2_valid_reg;
    logic                    e2_first_reg;
    logic [IDX_W-1:0]        e2_idx_reg;
    scrov_pkg::scrov_entry_t e2_ent_reg;
    logic signed [17:0]      e2_sx2_reg, e2_sy2_reg, e2_qx2_reg, e2_qy2_reg;
    logic signed [17:0]      e2_lox_reg, e2_loy_reg;

    // stage 3: overlap extents and containment
    logic                    e3_valid_reg;
    logic                    e3_first_reg;
    logic [IDX_W-1:0]        e3_idx_reg;
    scrov_pkg::scrov_entry_t e3_ent_reg;
    logic signed [17:0]      e3_sx2_reg, e3_sy2_reg;
    logic [15:0]             e3_dx_reg, e3_dy_reg;
    logic                    e3_ov_reg, e3_contain_reg;

    // stage 4: area
    logic                    e4_valid_reg;
    logic                    e4_first_reg;
    logic [IDX_W-1:0]        e4_idx_reg;
    scrov_pkg::scrov_entry_t e4_ent_reg;
    logic signed [17:0]      e4_sx2_reg, e4_sy2_reg;
    logic [31:0]             e4_area_reg;
    logic                    e4_ov_reg, e4_contain_reg;

    // accumulators
    logic                    found_reg;
    logic [31:0]             best_area_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    scrov_pkg::scrov_entry_t best_ent_reg;
    logic signed [15:0]      bx1_reg, by1_reg;
    logic signed [17:0]      bx2_reg, by2_reg;

    logic signed [15:0] ex, ey, qx, qy;
    logic signed [17:0] ex_ext, ey_ext, qx_ext, qy_ext;
    logic signed [17:0] sx2_c, sy2_c, qx2_c, qy2_c;
    logic signed [17:0] hix_c, hiy_c, dxw_c, dyw_c;
    logic               ovx_c, ovy_c, cx_c, cy_c;
    logic               take_rect, take_point;

    always_comb begin
        ex     = ent.x;
        ey     = ent.y;
        qx     = query.rect_x;
        qy     = query.rect_y;
        ex_ext = {{2{ex[15]}}, ex};
        ey_ext = {{2{ey[15]}}, ey};
        qx_ext = {{2{qx[15]}}, qx};
        qy_ext = {{2{qy[15]}}, qy};
        sx2_c  = ex_ext + {2'b00, ent.w};
        sy2_c  = ey_ext + {2'b00, ent.h};
        qx2_c  = qx_ext + {2'b00, query.rect_width};
        qy2_c  = qy_ext + {2'b00, query.rect_height};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_valid_reg <= 1'b0;
        end else begin
            e2_valid_reg <= ctl.ent_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ent_valid) begin
            e2_first_reg <= ctl.ent_first;
            e2_idx_reg   <= ent_idx;
            e2_ent_reg   <= ent;
            e2_sx2_reg   <= sx2_c;
            e2_sy2_reg   <= sy2_c;
            e2_qx2_reg   <= qx2_c;
            e2_qy2_reg   <= qy2_c;
            e2_lox_reg   <= (ex_ext > qx_ext) ? ex_ext : qx_ext;
            e2_loy_reg   <= (ey_ext > qy_ext) ? ey_ext : qy_ext;
        end
    end

    always_comb begin
        hix_c = (e2_sx2_reg < e2_qx2_reg) ? e2_sx2_reg : e2_qx2_reg;
        hiy_c = (e2_sy2_reg < e2_qy2_reg) ? e2_sy2_reg : e2_qy2_reg;
        dxw_c = hix_c - e2_lox_reg;
        dyw_c = hiy_c - e2_loy_reg;
        ovx_c = (e2_sx2_reg > e2_lox_reg) && (e2_qx2_reg > e2_lox_reg);
        ovy_c = (e2_sy2_reg > e2_loy_reg) && (e2_qy2_reg > e2_loy_reg);
        cx_c  = (qx_ext >= $signed({{2{e2_ent_reg.x[15]}}, e2_ent_reg.x})) &&
                (qx_ext < e2_sx2_reg);
        cy_c  = (qy_ext >= $signed({{2{e2_ent_reg.y[15]}}, e2_ent_reg.y})) &&
                (qy_ext < e2_sy2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e3_valid_reg <= 1'b0;
            e4_valid_reg <= 1'b0;
        end else begin
            e3_valid_reg <= e2_valid_reg;
            e4_valid_reg <= e3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e2_valid_reg) begin
            e3_first_reg   <= e2_first_reg;
            e3_idx_reg     <= e2_idx_reg;
            e3_ent_reg     <= e2_ent_reg;
            e3_sx2_reg     <= e2_sx2_reg;
            e3_sy2_reg     <= e2_sy2_reg;
            e3_dx_reg      <= dxw_c[15:0];
            e3_dy_reg      <= dyw_c[15:0];
            e3_ov_reg      <= ovx_c && ovy_c;
            e3_contain_reg <= cx_c && cy_c;
        end
        if (e3_valid_reg) begin
            e4_first_reg   <= e3_first_reg;
            e4_idx_reg     <= e3_idx_reg;
            e4_ent_reg     <= e3_ent_reg;
            e4_sx2_reg     <= e3_sx2_reg;
            e4_sy2_reg     <= e3_sy2_reg;
            e4_area_reg    <= e3_dx_reg * e3_dy_reg;
            e4_ov_reg      <= e3_ov_reg;
            e4_contain_reg <= e3_contain_reg;
        end
    end

    assign take_rect  = e4_valid_reg && (query.operation == scrov_pkg::OP_RECT) &&
                        e4_ov_reg && (e4_area_reg > best_area_reg);
    assign take_point = e4_valid_reg && (query.operation == scrov_pkg::OP_POINT) &&
                        e4_contain_reg && !found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (take_rect || take_point) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            best_area_reg <= '0;
        end else if (take_rect || take_point) begin
            best_area_reg <= e4_area_reg;
            best_idx_reg  <= e4_idx_reg;
            best_ent_reg  <= e4_ent_reg;
        end
        if (e4_valid_reg) begin
            if (e4_first_reg || e4_ent_reg.x < bx1_reg) begin
                bx1_reg <= e4_ent_reg.x;
            end
            if (e4_first_reg || e4_ent_reg.y < by1_reg) begin
                by1_reg <= e4_ent_reg.y;
            end
            if (e4_first_reg || e4_sx2_reg > bx2_reg) begin
                bx2_reg <= e4_sx2_reg;
            end
            if (e4_first_reg || e4_sy2_reg > by2_reg) begin
                by2_reg <= e4_sy2_reg;
            end
        end
    end

    assign sts.busy  = e2_valid_reg || e3_valid_reg || e4_valid_reg;
    assign sts.found = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_ent  = best_ent_reg;
    assign bound_x1  = bx1_reg;
    assign bound_y1  = by1_reg;
    assign bound_x2  = bx2_reg;
    assign bound_y2  = by2_reg;

    a_point_first_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && !ctl.start && query.operation == scrov_pkg::OP_POINT)
        |=> $stable(best_idx_reg))
        else $error("point match replaced after first hit");

    a_area_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        take_rect |=> (best_area_reg != 32'd0))
        else $error("rect match recorded with zero area");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> !sts.busy)
        else $error("walk restarted while entries in flight");

endmodule

/* rtl/screen_overlap_selector_unit.sv */
// Screen overlap selector: screen table memory, query sequencer and response register.
// Uses scrov_walk for per-entry evaluation; types from scrov_pkg.
//
// Usage: requests arrive on s_valid/s_ready/s_req. A write request stores one screen
// rectangle in the table and gives no response. A rect, point or total query walks
// table entries 0..n-1 (n = screen_count, capped at MAX_SCREENS), reading one entry
// per cycle from the table memory, and gives one response on m_valid/m_ready/m_rsp.
// With n = 0 the query goes straight to the finish state, which loads the default
// screen. Otherwise the finish state follows once the walk has drained; the single
// table read port sets the walk at one entry per cycle, and the next request is
// taken only after the load, once the sequencer is back in idle. A response waiting
// in the output register does not block the next request; a query finished while
// the receiver still stalls waits in its final state until the register frees.
// The user must write configuration on cfg_wr_en/cfg_index/cfg_wdata only while
// idle; the block itself does not enforce this. Reset clears the handshakes and sets
// screen_count 0, default size 1024 x 768; table entries hold no value until written.
module screen_overlap_selector_unit #(
    parameter int MAX_SCREENS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [scrov_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scrov_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  scrov_pkg::scrov_req_t               s_req,
    output logic                                m_valid,
    input  logic                                m_ready,
    output scrov_pkg::scrov_rsp_t               m_rsp
);

    localparam int IDX_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
    localparam int CNT_W = $clog2(MAX_SCREENS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  screen_count_reg;
    logic [15:0] default_width_reg, default_height_reg;

    scrov_pkg::scrov_req_t   req_reg;
    logic                    dflt_reg;
    logic [CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                    p1_valid_reg;
    logic [IDX_W-1:0]        p1_idx_reg;
    scrov_pkg::scrov_entry_t rd_data_reg;
    scrov_pkg::scrov_entry_t mem [MAX_SCREENS];

    logic                    m_valid_reg;
    scrov_pkg::scrov_rsp_t   m_rsp_reg;
    scrov_pkg::scrov_rsp_t   rsp_build;

    logic                    s_accept, is_write, start, mem_we, rd_issue, out_load;
    logic [7:0]              cnt_ext, wr_ext, best_ext;
    logic [CNT_W-1:0]        n_lim;
    logic [IDX_W-1:0]        wr_addr, rd_addr;
    scrov_pkg::scrov_entry_t wr_ent;

    scrov_pkg::scrov_walk_ctl_t walk_ctl;
    scrov_pkg::scrov_walk_sts_t walk_sts;
    logic [IDX_W-1:0]           best_idx;
    scrov_pkg::scrov_entry_t    best_ent;
    logic signed [15:0]         bound_x1, bound_y1;
    logic signed [17:0]         bound_x2, bound_y2;
    logic signed [18:0]         bound_w, bound_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_count_reg   <= scrov_pkg::SCREEN_COUNT_RST;
            default_width_reg  <= scrov_pkg::DEFAULT_WIDTH_RST;
            default_height_reg <= scrov_pkg::DEFAULT_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                scrov_pkg::CFG_SCREEN_COUNT:   screen_count_reg   <= cfg_wdata[3:0];
                scrov_pkg::CFG_DEFAULT_WIDTH:  default_width_reg  <= cfg_wdata;
                scrov_pkg::CFG_DEFAULT_HEIGHT: default_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cnt_ext = {4'd0, screen_count_reg};
        if (cnt_ext > 8'(MAX_SCREENS)) begin
            n_lim = CNT_W'(MAX_SCREENS);
        end else begin
            n_lim = cnt_ext[CNT_W-1:0];
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign is_write = (s_req.operation == scrov_pkg::OP_WRITE);
    assign wr_ext   = {5'd0, s_req.entry_index};
    assign wr_addr  = wr_ext[IDX_W-1:0];
    assign mem_we   = s_accept && is_write && (wr_ext < 8'(MAX_SCREENS));
    assign start    = s_accept && !is_write;
    assign rd_issue = (state_reg == ST_WALK) && (rd_cnt_reg < n_lim);
    assign rd_addr  = rd_cnt_reg[IDX_W-1:0];
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        wr_ent.x = s_req.rect_x;
        wr_ent.y = s_req.rect_y;
        wr_ent.w = s_req.rect_width;
        wr_ent.h = s_req.rect_height;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_ent;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr];
            p1_idx_reg  <= rd_addr;
        end
    end

    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                rd_cnt_next = '0;
                if (start) begin
                    state_next = (n_lim == '0) ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK: begin
                if (rd_issue) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end else if (!p1_valid_reg && !walk_sts.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            p1_valid_reg <= rd_issue;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            req_reg  <= s_req;
            dflt_reg <= (n_lim == '0);
        end
        if (out_load) begin
            m_rsp_reg <= rsp_build;
        end
    end

    assign walk_ctl.start     = start;
    assign walk_ctl.ent_valid = p1_valid_reg;
    assign walk_ctl.ent_first = (p1_idx_reg == '0);

    scrov_walk #(
        .IDX_W(IDX_W)
    ) u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (walk_ctl),
        .query    (req_reg),
        .ent_idx  (p1_idx_reg),
        .ent      (rd_data_reg),
        .sts      (walk_sts),
        .best_idx (best_idx),
        .best_ent (best_ent),
        .bound_x1 (bound_x1),
        .bound_y1 (bound_y1),
        .bound_x2 (bound_x2),
        .bound_y2 (bound_y2)
    );

    always_comb begin
        best_ext = 8'(best_idx);
        bound_w  = {bound_x2[17], bound_x2} - {{3{bound_x1[15]}}, bound_x1};
        bound_h  = {bound_y2[17], bound_y2} - {{3{bound_y1[15]}}, bound_y1};
        rsp_build.result_kind  = scrov_pkg::KIND_DEFAULT;
        rsp_build.screen_index = 3'd0;
        rsp_build.out_x        = 16'sd0;
        rsp_build.out_y        = 16'sd0;
        rsp_build.out_width    = default_width_reg;
        rsp_build.out_height   = default_height_reg;
        if (!dflt_reg) begin
            if (req_reg.operation == scrov_pkg::OP_TOTAL) begin
                rsp_build.result_kind = scrov_pkg::KIND_BOUND;
                rsp_build.out_x       = bound_x1;
                rsp_build.out_y       = bound_y1;
                rsp_build.out_width   = (bound_w > 19'sd65535) ? 16'hFFFF : bound_w[15:0];
                rsp_build.out_height  = (bound_h > 19'sd65535) ? 16'hFFFF : bound_h[15:0];
            end else if (walk_sts.found) begin
                rsp_build.result_kind  = scrov_pkg::KIND_ENTRY;
                rsp_build.screen_index = best_ext[2:0];
                rsp_build.out_x        = best_ent.x;
                rsp_build.out_y        = best_ent.y;
                rsp_build.out_width    = best_ent.w;
                rsp_build.out_height   = best_ent.h;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    a_rsp_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("response raised outside the finish state");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (rd_cnt_reg <= n_lim))
        else $error("table walk ran past the screen count");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!p1_valid_reg && !walk_sts.busy))
        else $error("entries in flight while idle");

    a_write_no_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_write) |=> (state_reg == ST_IDLE))
        else $error("write request started a query");

endmodule
